[hdl/sm4_pkg.sv]
// ----------------------------------------------------------------------------
// SM4 package
// Shared types, constants and round functions of the SM4 block cipher.
// ----------------------------------------------------------------------------
package sm4_pkg;

    localparam int unsigned ROUND_COUNT = 32;
    localparam int unsigned CNT_W       = $clog2(ROUND_COUNT);

    typedef enum logic [1:0] {
        REG_KEY_HIGH = 2'd0,
        REG_KEY_LOW  = 2'd1,
        REG_DECRYPT  = 2'd2
    } t_reg_idx;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_KEYX,
        ST_RUN
    } t_state;

    localparam logic [31:0] FK0 = 32'hA3B1BAC6;
    localparam logic [31:0] FK1 = 32'h56AA3350;
    localparam logic [31:0] FK2 = 32'h677D9197;
    localparam logic [31:0] FK3 = 32'hB27022DC;

    localparam logic [7:0] SBOX [256] = '{
        8'hD6, 8'h90, 8'hE9, 8'hFE, 8'hCC, 8'hE1, 8'h3D, 8'hB7, 8'h16, 8'hB6, 8'h14, 8'hC2,
        8'h28, 8'hFB, 8'h2C, 8'h05, 8'h2B, 8'h67, 8'h9A, 8'h76, 8'h2A, 8'hBE, 8'h04, 8'hC3,
        8'hAA, 8'h44, 8'h13, 8'h26, 8'h49, 8'h86, 8'h06, 8'h99, 8'h9C, 8'h42, 8'h50, 8'hF4,
        8'h91, 8'hEF, 8'h98, 8'h7A, 8'h33, 8'h54, 8'h0B, 8'h43, 8'hED, 8'hCF, 8'hAC, 8'h62,
        8'hE4, 8'hB3, 8'h1C, 8'hA9, 8'hC9, 8'h08, 8'hE8, 8'h95, 8'h80, 8'hDF, 8'h94, 8'hFA,
        8'h75, 8'h8F, 8'h3F, 8'hA6, 8'h47, 8'h07, 8'hA7, 8'hFC, 8'hF3, 8'h73, 8'h17, 8'hBA,
        8'h83, 8'h59, 8'h3C, 8'h19, 8'hE6, 8'h85, 8'h4F, 8'hA8, 8'h68, 8'h6B, 8'h81, 8'hB2,
        8'h71, 8'h64, 8'hDA, 8'h8B, 8'hF8, 8'hEB, 8'h0F, 8'h4B, 8'h70, 8'h56, 8'h9D, 8'h35,
        8'h1E, 8'h24, 8'h0E, 8'h5E, 8'h63, 8'h58, 8'hD1, 8'hA2, 8'h25, 8'h22, 8'h7C, 8'h3B,
        8'h01, 8'h21, 8'h78, 8'h87, 8'hD4, 8'h00, 8'h46, 8'h57, 8'h9F, 8'hD3, 8'h27, 8'h52,
        8'h4C, 8'h36, 8'h02, 8'hE7, 8'hA0, 8'hC4, 8'hC8, 8'h9E, 8'hEA, 8'hBF, 8'h8A, 8'hD2,
        8'h40, 8'hC7, 8'h38, 8'hB5, 8'hA3, 8'hF7, 8'hF2, 8'hCE, 8'hF9, 8'h61, 8'h15, 8'hA1,
        8'hE0, 8'hAE, 8'h5D, 8'hA4, 8'h9B, 8'h34, 8'h1A, 8'h55, 8'hAD, 8'h93, 8'h32, 8'h30,
        8'hF5, 8'h8C, 8'hB1, 8'hE3, 8'h1D, 8'hF6, 8'hE2, 8'h2E, 8'h82, 8'h66, 8'hCA, 8'h60,
        8'hC0, 8'h29, 8'h23, 8'hAB, 8'h0D, 8'h53, 8'h4E, 8'h6F, 8'hD5, 8'hDB, 8'h37, 8'h45,
        8'hDE, 8'hFD, 8'h8E, 8'h2F, 8'h03, 8'hFF, 8'h6A, 8'h72, 8'h6D, 8'h6C, 8'h5B, 8'h51,
        8'h8D, 8'h1B, 8'hAF, 8'h92, 8'hBB, 8'hDD, 8'hBC, 8'h7F, 8'h11, 8'hD9, 8'h5C, 8'h41,
        8'h1F, 8'h10, 8'h5A, 8'hD8, 8'h0A, 8'hC1, 8'h31, 8'h88, 8'hA5, 8'hCD, 8'h7B, 8'hBD,
        8'h2D, 8'h74, 8'hD0, 8'h12, 8'hB8, 8'hE5, 8'hB4, 8'hB0, 8'h89, 8'h69, 8'h97, 8'h4A,
        8'h0C, 8'h96, 8'h77, 8'h7E, 8'h65, 8'hB9, 8'hF1, 8'h09, 8'hC5, 8'h6E, 8'hC6, 8'h84,
        8'h18, 8'hF0, 8'h7D, 8'hEC, 8'h3A, 8'hDC, 8'h4D, 8'h20, 8'h79, 8'hEE, 8'h5F, 8'h3E,
        8'hD7, 8'hCB, 8'h39, 8'h48
    };

    function automatic logic [31:0] sub_word(input logic [31:0] v);
        sub_word = {SBOX[v[31:24]], SBOX[v[23:16]], SBOX[v[15:8]], SBOX[v[7:0]]};
    endfunction

    function automatic logic [31:0] rotl(input logic [31:0] v, input int unsigned n);
        rotl = (v << n) | (v >> (32 - n));
    endfunction

    // Byte j of constant i is ((4*i + j) * 7) mod 256.
    function automatic logic [31:0] ck_word(input logic [CNT_W-1:0] i);
        logic [7:0] b0;
        b0 = 8'({i, 2'b00});
        ck_word = {8'(b0 * 8'd7), 8'((b0 + 8'd1) * 8'd7),
                   8'((b0 + 8'd2) * 8'd7), 8'((b0 + 8'd3) * 8'd7)};
    endfunction

endpackage

[hdl/sm4_block_cipher.sv]
// The key schedule runs first when round keys are not current (after reset or a
// key write). A new block is taken only in idle, after the last block's rounds.
// One round per cycle on the shared round unit, the last one waiting while the
// output is stalled; round keys circulate in a 32-cell ring.
// Reset clears control state and the keys-ready flag; keys and mode reset to 0.
// ----------------------------------------------------------------------------
// SM4 block cipher
// 128-bit SM4 encrypt/decrypt with on-demand key schedule.
// ----------------------------------------------------------------------------
module sm4_block_cipher (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [1:0]   i_cfg_index,
    input  logic [63:0]  i_cfg_data,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    input  logic [127:0] i_s_axis_tdata,  // block_high [63:0], block_low [127:64]
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    output logic [127:0] o_m_axis_tdata   // result_high [63:0], result_low [127:64]
);
    import sm4_pkg::*;

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic               r_keys_ready, n_keys_ready;
    logic [63:0]        r_key_high, r_key_low;
    logic               r_decrypt;
    logic [127:0]       r_blk;
    logic               r_out_valid, n_out_valid;
    logic [127:0]       r_out;

    logic               s_acc, last, can_emit, adv, key_mode;
    logic               x_load, ring_dir;
    logic [31:0]        x_load_d [4];
    logic [31:0]        x_q [4];
    logic [31:0]        ring_q [ROUND_COUNT];
    logic [31:0]        ring_fwd_tail;
    logic [31:0]        rk, new_word;

    assign o_cfg_ready = 1'b1;
    assign s_acc       = i_s_axis_tvalid && o_s_axis_tready;
    assign last        = (r_cnt == CNT_W'(ROUND_COUNT - 1));
    assign can_emit    = !r_out_valid || i_m_axis_tready;
    assign key_mode    = (r_state == ST_KEYX);
    assign adv         = key_mode || ((r_state == ST_RUN) && (!last || can_emit));
    assign ring_dir    = (r_state == ST_RUN) && r_decrypt;
    assign rk          = key_mode ? ck_word(r_cnt)
                                  : (r_decrypt ? ring_q[ROUND_COUNT-1] : ring_q[0]);
    assign ring_fwd_tail = key_mode ? new_word : ring_q[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_high <= '0;
            r_key_low  <= '0;
            r_decrypt  <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_KEY_HIGH: r_key_high <= i_cfg_data;
                REG_KEY_LOW:  r_key_low  <= i_cfg_data;
                REG_DECRYPT:  r_decrypt  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        n_state      = r_state;
        n_cnt        = r_cnt;
        n_keys_ready = r_keys_ready;
        n_out_valid  = r_out_valid && !i_m_axis_tready;
        x_load       = 1'b0;
        x_load_d[0]  = i_s_axis_tdata[63:32];
        x_load_d[1]  = i_s_axis_tdata[31:0];
        x_load_d[2]  = i_s_axis_tdata[127:96];
        x_load_d[3]  = i_s_axis_tdata[95:64];
        o_s_axis_tready = (r_state == ST_IDLE);
        unique case (r_state)
            ST_IDLE: begin
                if (s_acc) begin
                    x_load = 1'b1;
                    n_cnt  = '0;
                    if (r_keys_ready) begin
                        n_state = ST_RUN;
                    end else begin
                        n_state     = ST_KEYX;
                        x_load_d[0] = r_key_high[63:32] ^ FK0;
                        x_load_d[1] = r_key_high[31:0]  ^ FK1;
                        x_load_d[2] = r_key_low[63:32]  ^ FK2;
                        x_load_d[3] = r_key_low[31:0]   ^ FK3;
                    end
                end
            end
            ST_KEYX: begin
                n_cnt = r_cnt + 1'b1;
                if (last) begin
                    n_state      = ST_RUN;
                    n_keys_ready = 1'b1;
                    x_load       = 1'b1;
                    x_load_d[0]  = r_blk[63:32];
                    x_load_d[1]  = r_blk[31:0];
                    x_load_d[2]  = r_blk[127:96];
                    x_load_d[3]  = r_blk[95:64];
                end
            end
            ST_RUN: begin
                if (adv) begin
                    n_cnt = r_cnt + 1'b1;
                    if (last) begin
                        n_state     = ST_IDLE;
                        n_out_valid = 1'b1;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
        if (i_cfg_valid && o_cfg_ready &&
            (i_cfg_index == REG_KEY_HIGH || i_cfg_index == REG_KEY_LOW)) begin
            n_keys_ready = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_cnt        <= '0;
            r_keys_ready <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_cnt        <= n_cnt;
            r_keys_ready <= n_keys_ready;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_blk <= i_s_axis_tdata;
        end
        if ((r_state == ST_RUN) && adv && last) begin
            r_out <= {x_q[2], x_q[1], new_word, x_q[3]};
        end
    end

    sm4_round u_round (
        .i_w0       (x_q[0]),
        .i_w1       (x_q[1]),
        .i_w2       (x_q[2]),
        .i_w3       (x_q[3]),
        .i_rk       (rk),
        .i_key_mode (key_mode),
        .o_word     (new_word)
    );

    for (genvar g = 0; g < 4; g++) begin : g_x
        sm4_cell u_cell (
            .i_clk    (i_clk),
            .i_load   (x_load),
            .i_load_d (x_load_d[g]),
            .i_shift  (adv),
            .i_dir    (1'b0),
            .i_fwd    ((g == 3) ? new_word : x_q[(g + 1) % 4]),
            .i_bwd    (x_q[g]),
            .o_q      (x_q[g])
        );
    end

    for (genvar g = 0; g < ROUND_COUNT; g++) begin : g_ring
        sm4_cell u_cell (
            .i_clk    (i_clk),
            .i_load   (1'b0),
            .i_load_d (ring_q[g]),
            .i_shift  (adv),
            .i_dir    (ring_dir),
            .i_fwd    ((g == ROUND_COUNT - 1) ? ring_fwd_tail
                                              : ring_q[(g + 1) % ROUND_COUNT]),
            .i_bwd    (ring_q[(g + ROUND_COUNT - 1) % ROUND_COUNT]),
            .o_q      (ring_q[g])
        );
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out;
endmodule

[hdl/sm4_cell.sv]
// ----------------------------------------------------------------------------
// SM4 cell
// One 32-bit word of a shift chain; loads, or takes a neighbor's word.
// ----------------------------------------------------------------------------
module sm4_cell (
    input  logic        i_clk,
    input  logic        i_load,
    input  logic [31:0] i_load_d,
    input  logic        i_shift,
    input  logic        i_dir,
    input  logic [31:0] i_fwd,
    input  logic [31:0] i_bwd,
    output logic [31:0] o_q
);
    logic [31:0] r_q;
    logic [31:0] n_q;

    always_comb begin
        n_q = r_q;
        if (i_load) begin
            n_q = i_load_d;
        end else if (i_shift) begin
            n_q = i_dir ? i_bwd : i_fwd;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q <= n_q;
    end

    assign o_q = r_q;
endmodule

[hdl/sm4_round.sv]
// ----------------------------------------------------------------------------
// SM4 round unit
// Shared S-box and linear mix for data rounds and key expansion rounds.
// ----------------------------------------------------------------------------
module sm4_round (
    input  logic [31:0] i_w0,
    input  logic [31:0] i_w1,
    input  logic [31:0] i_w2,
    input  logic [31:0] i_w3,
    input  logic [31:0] i_rk,
    input  logic        i_key_mode,
    output logic [31:0] o_word
);
    import sm4_pkg::*;

    logic [31:0] t;
    logic [31:0] mix;

    always_comb begin
        t = sub_word(i_w1 ^ i_w2 ^ i_w3 ^ i_rk);
        if (i_key_mode) begin
            mix = t ^ rotl(t, 13) ^ rotl(t, 23);
        end else begin
            mix = t ^ rotl(t, 2) ^ rotl(t, 10) ^ rotl(t, 18) ^ rotl(t, 24);
        end
        o_word = i_w0 ^ mix;
    end
endmodule

[hdl/sm4_checker.sv]
// ----------------------------------------------------------------------------
// SM4 port checker
// Checks the cipher's port behavior over time; bound to the top level.
// ----------------------------------------------------------------------------
module sm4_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         i_cfg_valid,
    input logic         o_cfg_ready,
    input logic         i_s_axis_tvalid,
    input logic         o_s_axis_tready,
    input logic         o_m_axis_tvalid,
    input logic         i_m_axis_tready,
    input logic [127:0] o_m_axis_tdata
);
    logic s_acc;
    assign s_acc = i_s_axis_tvalid && o_s_axis_tready;

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_acc |=> !o_s_axis_tready)
        else $error("input ready high right after an accepted word");

    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_acc && (!o_m_axis_tvalid || i_m_axis_tready) |=> !o_m_axis_tvalid)
        else $error("result appeared one cycle after input");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("stalled result word changed");

    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid |-> o_cfg_ready)
        else $error("configuration write refused");
endmodule

bind sm4_block_cipher sm4_checker u_sm4_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_cfg_valid     (i_cfg_valid),
    .o_cfg_ready     (o_cfg_ready),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);
